/* design/hbsg_pkg.sv */
// Shared types, constants and helpers for the HUB75 bit-plane scan generator.
// No dependencies; every other design file imports this package.
package hbsg_pkg;

   localparam int PANEL_WIDTH = 64;
   localparam int SCAN_ROWS   = 16;
   localparam int BIT_PLANES  = 5;

   localparam logic [7:0] LAST_COLUMN = 8'(PANEL_WIDTH - 1);
   localparam logic [3:0] LAST_ROW    = 4'(SCAN_ROWS - 1);
   localparam logic [2:0] LAST_PLANE  = 3'(BIT_PLANES - 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] red_top;
      logic [7:0] green_top;
      logic [7:0] blue_top;
      logic [7:0] red_bottom;
      logic [7:0] green_bottom;
      logic [7:0] blue_bottom;
   } req_type;

   typedef struct packed {
      logic       blank;
      logic       latch;
      logic       shift_clk;
      logic [3:0] row_addr;
      logic       pin_r1;
      logic       pin_g1;
      logic       pin_b1;
      logic       pin_r2;
      logic       pin_g2;
      logic       pin_b2;
      logic       run_end;
      logic       frame_done;
   } rsp_type;

   // One classified pixel pair, as handed from the front to the back.
   typedef struct packed {
      logic       first_col;
      logic       last_col;
      logic       frame_end;
      logic [3:0] row;
      logic [5:0] data;   // r1 g1 b1 r2 g2 b2 in bits 0 to 5
   } cmd_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   // Bit of the 5-bit reduced colour (top five bits) selected by the plane.
   function automatic logic plane_bit(logic [7:0] value, logic [2:0] plane);
      logic [7:0] reduced;
      reduced = value >> 3;
      reduced = reduced >> plane;
      return reduced[0];
   endfunction

endpackage

/* design/hbsg_front.sv */
// Front end: accepts pixel pairs, tracks plane/row/column and classifies each pair.
// Depends on hbsg_pkg.
module hbsg_front import hbsg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    queue_push,
   output cmd_type queue_cmd
);

   logic [7:0] column_ff, column_in;
   logic [3:0] row_ff, row_in;
   logic [2:0] plane_ff, plane_in;
   logic       row_last, plane_last, col_last;

   assign req_ready  = !queue_full;
   assign queue_push = req_valid && !queue_full;

   always_comb begin
      col_last   = (column_ff == LAST_COLUMN);
      row_last   = (row_ff == LAST_ROW);
      plane_last = (plane_ff == LAST_PLANE);

      queue_cmd.first_col = (column_ff == 8'd0);
      queue_cmd.last_col  = col_last;
      queue_cmd.frame_end = row_last && plane_last;
      queue_cmd.row       = row_ff;
      queue_cmd.data[0]   = plane_bit(req_data.red_top, plane_ff);
      queue_cmd.data[1]   = plane_bit(req_data.green_top, plane_ff);
      queue_cmd.data[2]   = plane_bit(req_data.blue_top, plane_ff);
      queue_cmd.data[3]   = plane_bit(req_data.red_bottom, plane_ff);
      queue_cmd.data[4]   = plane_bit(req_data.green_bottom, plane_ff);
      queue_cmd.data[5]   = plane_bit(req_data.blue_bottom, plane_ff);

      column_in = column_ff;
      row_in    = row_ff;
      plane_in  = plane_ff;
      if (queue_push) begin
         if (col_last) begin
            column_in = 8'd0;
            if (row_last) begin
               row_in   = 4'd0;
               plane_in = plane_last ? 3'd0 : plane_ff + 3'd1;
            end else begin
               row_in = row_ff + 4'd1;
            end
         end else begin
            column_in = column_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 8'd0;
         row_ff    <= 4'd0;
         plane_ff  <= 3'd0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         plane_ff  <= plane_in;
      end
   end

endmodule

/* design/hbsg_queue.sv */
// Short command queue between the front and back ends.
// Depends on hbsg_pkg.
module hbsg_queue import hbsg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  queue_ctl_type ctl_in,
   output logic          full,
   output logic          empty,
   input  cmd_type       wr_cmd,
   output cmd_type       rd_cmd
);

   cmd_type             slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full   = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign rd_cmd = slots_ff[rd_ptr_ff];

   always_comb begin
      do_push   = ctl_in.push && !full;
      do_pop    = ctl_in.pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/hbsg_back.sv */
// Back end: steps each queued command through its pin states into the output register.
// Depends on hbsg_pkg.
module hbsg_back import hbsg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    queue_empty,
   input  cmd_type head_cmd,
   output logic    queue_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [2:0] PH_PRESET   = 3'd0;
   localparam logic [2:0] PH_LOW      = 3'd1;
   localparam logic [2:0] PH_HIGH     = 3'd2;
   localparam logic [2:0] PH_LATCH_HI = 3'd3;
   localparam logic [2:0] PH_LATCH_LO = 3'd4;

   logic [2:0] phase_ff, phase_in, cur_phase;
   logic       blank_ff, blank_in;
   logic       latch_ff, latch_in;
   logic       clk_ff, clk_in;
   logic [3:0] row_ff, row_in;
   logic [5:0] data_ff, data_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       fire, run_end, frame_done, last_step;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign fire      = !queue_empty && (!rsp_valid_ff || rsp_ready);
   assign queue_pop = fire && last_step;

   always_comb begin
      // A command that does not start a row skips the blanking preset.
      cur_phase = phase_ff;
      if (phase_ff == PH_PRESET && !head_cmd.first_col) begin
         cur_phase = PH_LOW;
      end

      blank_in   = blank_ff;
      latch_in   = latch_ff;
      clk_in     = clk_ff;
      row_in     = row_ff;
      data_in    = data_ff;
      run_end    = 1'b0;
      frame_done = 1'b0;
      last_step  = 1'b0;
      phase_in   = phase_ff;

      case (cur_phase)
         PH_PRESET: begin
            blank_in = 1'b1;
            row_in   = head_cmd.row;
            data_in  = 6'd0;
            phase_in = PH_LOW;
         end
         PH_LOW: begin
            data_in  = head_cmd.data;
            clk_in   = 1'b0;
            phase_in = PH_HIGH;
         end
         PH_HIGH: begin
            clk_in = 1'b1;
            if (head_cmd.last_col) begin
               phase_in = PH_LATCH_HI;
            end else begin
               run_end   = 1'b1;
               last_step = 1'b1;
               phase_in  = PH_PRESET;
            end
         end
         PH_LATCH_HI: begin
            latch_in = 1'b1;
            phase_in = PH_LATCH_LO;
         end
         PH_LATCH_LO: begin
            latch_in   = 1'b0;
            blank_in   = 1'b0;
            run_end    = 1'b1;
            frame_done = head_cmd.frame_end;
            last_step  = 1'b1;
            phase_in   = PH_PRESET;
         end
         default: begin
            last_step = 1'b1;
            phase_in  = PH_PRESET;
         end
      endcase

      rsp_data_in.blank      = blank_in;
      rsp_data_in.latch      = latch_in;
      rsp_data_in.shift_clk  = clk_in;
      rsp_data_in.row_addr   = row_in;
      rsp_data_in.pin_r1     = data_in[0];
      rsp_data_in.pin_g1     = data_in[1];
      rsp_data_in.pin_b1     = data_in[2];
      rsp_data_in.pin_r2     = data_in[3];
      rsp_data_in.pin_g2     = data_in[4];
      rsp_data_in.pin_b2     = data_in[5];
      rsp_data_in.run_end    = run_end;
      rsp_data_in.frame_done = frame_done;

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PRESET;
         blank_ff     <= 1'b0;
         latch_ff     <= 1'b0;
         clk_ff       <= 1'b0;
         row_ff       <= 4'd0;
         data_ff      <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            blank_ff <= blank_in;
            latch_ff <= latch_in;
            clk_ff   <= clk_in;
            row_ff   <= row_in;
            data_ff  <= data_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* design/hub75_bitplane_scan_generator_top.sv */
// HUB75 bit-plane scan generator.
// Input channel (req_): one pixel pair per beat, upper and lower half RGB, sent in
// scan order: column within row within bit plane. Result channel (rsp_): one full
// panel pin state per beat. A pair gives two beats (data with shift clock low, then
// high); a pair at column 0 is preceded by a blanking preset beat, and a pair at the
// last column is followed by latch high and latch low beats. run_end marks the last
// beat of each pair, frame_done the final beat of the last row of the last plane.
// The front end counts position and reduces colours to one bit per plane; a
// four-entry command queue lets it take pairs while the back end is still emitting.
// The back end produces one beat per cycle into a registered output while the queue
// holds a command and the receiver is not stalling; the first beat of a pair
// passes through the command queue and then the output register. Reset clears the
// counters, the queue and the pin levels held in the back end, but not the output
// register. When the receiver stalls the output beat holds, the back end pauses, and
// req_ready drops once the queue is full. Depends on hbsg_pkg, hbsg_front, hbsg_queue
// and hbsg_back.
module hub75_bitplane_scan_generator_top import hbsg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   queue_ctl_type queue_ctl;
   cmd_type       push_cmd;
   cmd_type       head_cmd;
   logic          queue_full;
   logic          queue_empty;
   logic          queue_push;
   logic          queue_pop;

   always_comb begin
      queue_ctl.push = queue_push;
      queue_ctl.pop  = queue_pop;
   end

   hbsg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_cmd  (push_cmd)
   );

   hbsg_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (queue_ctl),
      .full   (queue_full),
      .empty  (queue_empty),
      .wr_cmd (push_cmd),
      .rd_cmd (head_cmd)
   );

   hbsg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

/* tb/hub75_bitplane_scan_generator_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for hub75_bitplane_scan_generator_top: a directed table, then
// random pixel pairs across the first row ends, checked beat by beat against a predictor.
// Depends on hbsg_pkg and the scan generator RTL.
module hub75_bitplane_scan_generator_top_tb;
   import hbsg_pkg::*;

   localparam int STALL_LIMIT   = 1000;
   localparam int HOLD_CYCLES   = 60;
   localparam int RANDOM_PIXELS = 80;
   localparam int DRAIN_CYCLES  = 20;
   localparam int IDLE_PERCENT  = 11;
   localparam int PRINT_LIMIT   = 40;

   typedef struct {
      req_type px;
      bit      typed;
      rsp_type first;
   } pixel_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Scan position and pin levels as the panel should see them.
   logic [2:0] plane_ix = '0;
   logic [3:0] row_ix = '0;
   logic [7:0] col_ix = '0;
   rsp_type    pins = '0;

   rsp_type       expected_pins[$];
   pixel_row_type pixel_table[$];
   logic          hold_rsp = 1'b0;
   int            pixels_accepted = 0;
   int            beats_checked = 0;
   int            mismatch_count = 0;

   hub75_bitplane_scan_generator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("ERROR at %0t ns, beat %0d: %s", $time, beats_checked, what);
   endtask

   function automatic rsp_type pin_state(input bit blank, input bit latch, input bit clk,
                                         input logic [3:0] row, input logic [5:0] data,
                                         input bit run_end, input bit done);
      rsp_type s;
      s.blank      = blank;
      s.latch      = latch;
      s.shift_clk  = clk;
      s.row_addr   = row;
      s.pin_r1     = data[0];
      s.pin_g1     = data[1];
      s.pin_b1     = data[2];
      s.pin_r2     = data[3];
      s.pin_g2     = data[4];
      s.pin_b2     = data[5];
      s.run_end    = run_end;
      s.frame_done = done;
      return s;
   endfunction

   function automatic rsp_type pins_with_flags(input bit run_end, input bit done);
      rsp_type s;
      s = pins;
      s.run_end    = run_end;
      s.frame_done = done;
      return s;
   endfunction

   // Works out the pin states one pixel pair produces and advances the scan position.
   // A typed first beat replaces the predicted one for table rows that carry it.
   task automatic predict_pixel(input req_type px, input bit typed, input rsp_type first);
      rsp_type beats[$];
      bit      last_col;
      bit      frame_end;
      int      bitpos;
      bitpos   = 3 + int'(plane_ix);
      last_col = int'(col_ix) + 1 >= PANEL_WIDTH;
      if (col_ix == '0) begin
         pins.blank    = 1'b1;
         pins.row_addr = row_ix;
         {pins.pin_r1, pins.pin_g1, pins.pin_b1} = 3'b000;
         {pins.pin_r2, pins.pin_g2, pins.pin_b2} = 3'b000;
         beats.push_back(pins_with_flags(1'b0, 1'b0));
      end
      pins.pin_r1    = px.red_top[bitpos];
      pins.pin_g1    = px.green_top[bitpos];
      pins.pin_b1    = px.blue_top[bitpos];
      pins.pin_r2    = px.red_bottom[bitpos];
      pins.pin_g2    = px.green_bottom[bitpos];
      pins.pin_b2    = px.blue_bottom[bitpos];
      pins.shift_clk = 1'b0;
      beats.push_back(pins_with_flags(1'b0, 1'b0));
      pins.shift_clk = 1'b1;
      beats.push_back(pins_with_flags(!last_col, 1'b0));
      if (last_col) begin
         frame_end = (int'(row_ix) + 1 >= SCAN_ROWS) && (int'(plane_ix) + 1 >= BIT_PLANES);
         pins.latch = 1'b1;
         beats.push_back(pins_with_flags(1'b0, 1'b0));
         pins.latch = 1'b0;
         pins.blank = 1'b0;
         beats.push_back(pins_with_flags(1'b1, frame_end));
         col_ix = '0;
         if (int'(row_ix) + 1 >= SCAN_ROWS) begin
            row_ix   = '0;
            plane_ix = (int'(plane_ix) + 1 >= BIT_PLANES) ? 3'd0 : plane_ix + 3'd1;
         end else begin
            row_ix = row_ix + 4'd1;
         end
      end else begin
         col_ix = col_ix + 8'd1;
      end
      if (typed)
         beats[0] = first;
      foreach (beats[i])
         expected_pins.push_back(beats[i]);
   endtask

   task automatic add_row(input req_type px, input bit typed, input rsp_type first);
      pixel_row_type r;
      r.px    = px;
      r.typed = typed;
      r.first = first;
      pixel_table.push_back(r);
   endtask

   // Offers one pixel pair and holds it until the block takes it.
   task automatic offer_pixel(input req_type px, input bit typed, input rsp_type first,
                              input bit steady);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predict_pixel(px, typed, first);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      pixels_accepted++;
   endtask

   task automatic check_field(input string name, input logic [3:0] got,
                              input logic [3:0] want);
      if (got !== want)
         report($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic check_flag(input string name, input logic got, input logic want);
      if (got !== want)
         report($sformatf("%s is %0b, expected %0b", name, got, want));
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (expected_pins.size() == 0) begin
         report($sformatf("pin state %h arrived with nothing expected", got));
      end else begin
         want = expected_pins.pop_front();
         check_flag("blank", got.blank, want.blank);
         check_flag("latch", got.latch, want.latch);
         check_flag("shift_clk", got.shift_clk, want.shift_clk);
         check_field("row_addr", got.row_addr, want.row_addr);
         check_flag("pin_r1", got.pin_r1, want.pin_r1);
         check_flag("pin_g1", got.pin_g1, want.pin_g1);
         check_flag("pin_b1", got.pin_b1, want.pin_b1);
         check_flag("pin_r2", got.pin_r2, want.pin_r2);
         check_flag("pin_g2", got.pin_g2, want.pin_g2);
         check_flag("pin_b2", got.pin_b2, want.pin_b2);
         check_flag("run_end", got.run_end, want.run_end);
         check_flag("frame_done", got.frame_done, want.frame_done);
      end
      beats_checked++;
   endtask

   // Receiver: checks each beat and stalls at random, except in a steady window
   // and while the long hold-off is running.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_beat(rsp_data);
         rsp_ready <= !hold_rsp && ((beats_checked >= 60 && beats_checked < 130) ||
                                    $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Long receiver stall so the command queue fills and req_ready drops.
   initial begin : rsp_pressure
      wait (pixels_accepted >= 40);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      req_type     px;
      logic [47:0] raw;
      int          n;
      // Blanking preset right after reset, then data with all colour bits set.
      add_row({6{8'hFF}}, 1'b1, pin_state(1, 0, 0, 4'd0, 6'h00, 0, 0));
      add_row({6{8'hFF}}, 1'b1, pin_state(1, 0, 0, 4'd0, 6'h3F, 0, 0));
      add_row({6{8'h00}}, 1'b1, pin_state(1, 0, 0, 4'd0, 6'h00, 0, 0));
      // The three low colour bits are dropped; plane 0 uses bit 3.
      add_row({6{8'h07}}, 1'b1, pin_state(1, 0, 0, 4'd0, 6'h00, 0, 0));
      add_row({6{8'hF7}}, 1'b1, pin_state(1, 0, 0, 4'd0, 6'h00, 0, 0));
      add_row({6{8'h08}}, 1'b1, pin_state(1, 0, 0, 4'd0, 6'h3F, 0, 0));
      for (int f = 0; f < 6; f++) begin
         add_row(req_type'(48'h08 << (8 * f)), 1'b0, '0);
         add_row(req_type'(~(48'h08 << (8 * f))), 1'b0, '0);
      end
      add_row(48'hA5_5A_A5_5A_A5_5A, 1'b0, '0);
      add_row(48'h5A_A5_5A_A5_5A_A5, 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (pixel_table[i])
         offer_pixel(pixel_table[i].px, pixel_table[i].typed, pixel_table[i].first, 1'b0);

      // The random part runs past the end of the first row into the next one.
      for (n = 0; n < RANDOM_PIXELS; n++) begin
         raw = {$urandom(), 16'($urandom())};
         px  = raw;
         case ($urandom_range(15))
            0:       px = '0;
            1:       px = '1;
            default: ;
         endcase
         offer_pixel(px, 1'b0, '0, n >= 30 && n < 60);
      end
      req_valid <= 1'b0;

      while (expected_pins.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d pixel pairs through %0d pin states: row presets, row latches",
               pixels_accepted, beats_checked);
      $display("and colour bit cases, with random stalls on both sides and a long hold.");
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* filelist.f */
design/hbsg_pkg.sv
design/hbsg_front.sv
design/hbsg_queue.sv
design/hbsg_back.sv
design/hub75_bitplane_scan_generator_top.sv
tb/hub75_bitplane_scan_generator_top_tb.sv
